[rtl/core/lscp_pkg.sv]
`default_nettype none
package lscp_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR     = 2'd0,
        CMD_CALIBRATE = 2'd1,
        CMD_COMPUTE   = 2'd2,
        CMD_NOP       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LANE,
        ST_SUM,
        ST_DIV,
        ST_DONE,
        ST_OUT
    } state_t;

    localparam int unsigned FULL_SCALE  = 1000;
    localparam int unsigned WEIGHT_STEP = 100;
    localparam int unsigned CENTRE      = 200;
    localparam int unsigned SCALED_BITS = 10;
    localparam int unsigned POS_BITS    = 9;
    localparam int unsigned THR_BITS    = 10;
    localparam int unsigned EDGE_BITS   = 8;
    localparam int unsigned CFG_BITS    = 10;

    localparam logic CFG_LINE_THRESHOLD = 1'b0;
    localparam logic CFG_EDGE_POSITION  = 1'b1;

    typedef struct packed {
        logic start;
        logic clear;
        logic calibrate;
        logic compute;
    } lane_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/lscp_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module lscp_div #(
    parameter int unsigned NUM_BITS = 20,
    parameter int unsigned DEN_BITS = 11
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     done,
    output logic      [NUM_BITS-1:0] quot
);
    localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quot_reg, quot_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_BITS-1:0], quot_reg[NUM_BITS-1]};
        if (start) begin
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

[rtl/core/lscp_lane.sv]
`default_nettype none
// One sensor channel: holds its calibration range and scales a sample.
// The scaling division runs bit-serially through the lane's own divider.
module lscp_lane #(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire lscp_pkg::lane_ctrl_t    ctrl,
    input  wire logic [SAMPLE_BITS-1:0]  sample,
    output logic                         done,
    output logic [lscp_pkg::SCALED_BITS-1:0] scaled
);
    localparam int unsigned RB = SAMPLE_BITS + 1;
    localparam int unsigned NB = SAMPLE_BITS + 10;

    logic [RB-1:0] max_reg, min_reg;
    logic [RB-1:0] clamped, span;
    logic          zero_span_reg;
    logic          div_done, fast_reg;
    logic [NB-1:0] prod, quot;
    logic [NB-1:0] prod_reg;
    logic [RB-1:0] span_reg;
    logic          div_start_reg;
    logic [lscp_pkg::SCALED_BITS-1:0] scaled_reg;
    logic          done_reg;

    always_comb begin
        clamped = {1'b0, sample};
        if (clamped < min_reg) clamped = min_reg;
        if (clamped > max_reg) clamped = max_reg;
        span = max_reg - min_reg;
        prod = NB'(clamped - min_reg) * NB'(lscp_pkg::FULL_SCALE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= '0;
            min_reg <= RB'(1) << SAMPLE_BITS;
            div_start_reg <= 1'b0;
            fast_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            fast_reg <= 1'b0;
            done_reg <= 1'b0;
            if (ctrl.start && ctrl.clear) begin
                max_reg <= '0;
                min_reg <= RB'(1) << SAMPLE_BITS;
            end
            if (ctrl.start && ctrl.calibrate) begin
                if ({1'b0, sample} > max_reg) max_reg <= {1'b0, sample};
                if ({1'b0, sample} < min_reg) min_reg <= {1'b0, sample};
            end
            if (ctrl.start && ctrl.compute) begin
                if (min_reg >= max_reg) fast_reg <= 1'b1;
                else div_start_reg <= 1'b1;
            end
            if (fast_reg || div_done) done_reg <= 1'b1;
        end
        if (ctrl.start) begin
            zero_span_reg <= min_reg == max_reg;
            prod_reg      <= prod;
            span_reg      <= span;
        end
        if (fast_reg)
            scaled_reg <= zero_span_reg ? lscp_pkg::SCALED_BITS'(lscp_pkg::FULL_SCALE) : '0;
        else if (div_done)
            scaled_reg <= lscp_pkg::SCALED_BITS'(NB'(lscp_pkg::FULL_SCALE) - quot);
    end

    lscp_div #(.NUM_BITS(NB), .DEN_BITS(RB)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .num(prod_reg), .den(span_reg), .done(div_done), .quot(quot)
    );

    assign done   = done_reg;
    assign scaled = scaled_reg;
endmodule
`default_nettype wire

[rtl/core/line_sensor_calibrate_position_top.sv]
`default_nettype none
// Line sensor calibration and line position.
// Input channel s_*: a command and one raw sample per sensor. Clear resets
// every channel range, calibrate widens them, compute scales every sample to
// 0..1000 (inverted) and reports the weighted centroid minus 200, or the signed edge position when the line is lost.
// Output channel m_*: one result per request, holding position, line_found
// and the scaled values (zero unless computing).
// Configuration: cfg_we, cfg_index, cfg_data; index 0 is line_threshold,
// index 1 edge_position. Write only while idle.
// Sequencing: clear, calibrate and the unused command go from idle through
// ST_DONE to ST_OUT, where m_valid rises. Compute runs one bit-serial divider per
// lane in parallel, sums the lanes one per cycle and then runs the centroid
// divider, which is skipped when the line is lost. One request is in flight
// at a time; s_ready returns in the cycle after the result is taken.
// Reset restores threshold 300, edge 190, empty ranges and position 0.
// When the receiver stalls, the result holds in m_* and no request is taken.
module line_sensor_calibrate_position_top #(
    parameter int unsigned SENSOR_COUNT = 5,
    parameter int unsigned SAMPLE_BITS  = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [lscp_pkg::CFG_BITS-1:0] cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_cmd,
    input  wire logic [SAMPLE_BITS-1:0] s_sample [SENSOR_COUNT],
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [lscp_pkg::POS_BITS-1:0] m_position,
    output logic                        m_line_found,
    output logic [lscp_pkg::SCALED_BITS-1:0] m_scaled [SENSOR_COUNT]
);
    localparam int unsigned SB  = lscp_pkg::SCALED_BITS;
    localparam int unsigned WMAX = (SENSOR_COUNT - 1) * lscp_pkg::WEIGHT_STEP;
    localparam int unsigned NUMB = $clog2(SENSOR_COUNT * 1000 * WMAX + 1);
    localparam int unsigned DENB = $clog2(SENSOR_COUNT * 1000 + 1);
    localparam int unsigned IB  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    lscp_pkg::state_t state_reg, state_next;
    lscp_pkg::cmd_t   cmd_reg;
    lscp_pkg::lane_ctrl_t ctrl;
    logic [lscp_pkg::THR_BITS-1:0]  thr_reg;
    logic [lscp_pkg::EDGE_BITS-1:0] edge_reg;
    logic signed [lscp_pkg::POS_BITS-1:0] last_reg;
    logic [SENSOR_COUNT-1:0] lane_done;
    logic [SENSOR_COUNT-1:0] done_reg;
    logic [SB-1:0] scaled [SENSOR_COUNT];
    logic [NUMB-1:0] num_reg;
    logic [DENB-1:0] den_reg;
    logic hit_reg;
    logic [IB-1:0] idx_reg;
    logic div_start, div_done;
    logic [NUMB-1:0] quot;
    logic signed [NUMB+1:0] pos_full;
    logic out_valid_reg;
    logic found_reg;
    logic [SB-1:0] out_scaled_reg [SENSOR_COUNT];
    logic [NUMB-1:0] term;
    logic [DENB-1:0] den_all;
    logic hit_all;

    assign s_ready = (state_reg == lscp_pkg::ST_IDLE);

    always_comb begin
        ctrl.start     = s_valid && s_ready;
        ctrl.clear     = s_cmd == lscp_pkg::CMD_CLEAR;
        ctrl.calibrate = s_cmd == lscp_pkg::CMD_CALIBRATE;
        ctrl.compute   = s_cmd == lscp_pkg::CMD_COMPUTE;
    end

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        lscp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
            .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .sample(s_sample[g]),
            .done(lane_done[g]), .scaled(scaled[g])
        );
    end

    // Merging stage: weighted sum goes one lane per cycle.
    assign term = NUMB'(scaled[idx_reg]) * NUMB'(WMAX / (SENSOR_COUNT - 1)) * NUMB'(idx_reg);
    // The last lane's value is folded in here so the decision sees every lane.
    assign den_all = den_reg + DENB'(scaled[idx_reg]);
    assign hit_all = hit_reg || (scaled[idx_reg] >= thr_reg);
    assign div_start = (state_reg == lscp_pkg::ST_SUM) &&
                       (idx_reg == IB'(SENSOR_COUNT - 1)) && hit_all && (den_all != '0);

    lscp_div #(.NUM_BITS(NUMB), .DEN_BITS(DENB)) u_cdiv (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(num_reg + term), .den(den_all),
        .done(div_done), .quot(quot)
    );

    assign pos_full = $signed({2'b00, quot}) - (NUMB+2)'(lscp_pkg::CENTRE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lscp_pkg::ST_IDLE: if (ctrl.start)
                state_next = ctrl.compute ? lscp_pkg::ST_LANE : lscp_pkg::ST_DONE;
            lscp_pkg::ST_LANE: if (&(done_reg | lane_done)) state_next = lscp_pkg::ST_SUM;
            lscp_pkg::ST_SUM: if (idx_reg == IB'(SENSOR_COUNT - 1))
                state_next = div_start ? lscp_pkg::ST_DIV : lscp_pkg::ST_DONE;
            lscp_pkg::ST_DIV: if (div_done) state_next = lscp_pkg::ST_DONE;
            lscp_pkg::ST_DONE: state_next = lscp_pkg::ST_OUT;
            lscp_pkg::ST_OUT: if (m_ready) state_next = lscp_pkg::ST_IDLE;
            default: state_next = lscp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lscp_pkg::ST_IDLE;
            thr_reg   <= lscp_pkg::THR_BITS'(300);
            edge_reg  <= lscp_pkg::EDGE_BITS'(190);
            last_reg  <= '0;
            out_valid_reg <= 1'b0;
            done_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == lscp_pkg::CFG_LINE_THRESHOLD) thr_reg <= cfg_data;
                else edge_reg <= cfg_data[lscp_pkg::EDGE_BITS-1:0];
            end
            if (state_reg == lscp_pkg::ST_LANE) done_reg <= done_reg | lane_done;
            else done_reg <= '0;
            if (state_reg == lscp_pkg::ST_DONE) begin
                out_valid_reg <= 1'b1;
                if (cmd_reg == lscp_pkg::CMD_COMPUTE) begin
                    if (found_reg) begin
                        if (pos_full > 255) last_reg <= 9'sd255;
                        else if (pos_full < -256) last_reg <= -9'sd256;
                        else last_reg <= pos_full[lscp_pkg::POS_BITS-1:0];
                    end else if (last_reg > 0) begin
                        last_reg <= $signed({1'b0, edge_reg});
                    end else begin
                        last_reg <= -$signed({1'b0, edge_reg});
                    end
                end
            end
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
        end
        if (ctrl.start) begin
            cmd_reg <= lscp_pkg::cmd_t'(s_cmd);
            num_reg <= '0;
            den_reg <= '0;
            hit_reg <= 1'b0;
            idx_reg <= '0;
            found_reg <= 1'b0;
        end
        if (state_reg == lscp_pkg::ST_SUM) begin
            num_reg <= num_reg + term;
            den_reg <= den_all;
            hit_reg <= hit_all;
            if (idx_reg != IB'(SENSOR_COUNT - 1)) idx_reg <= idx_reg + 1'b1;
            found_reg <= div_start;
        end
        if (state_reg == lscp_pkg::ST_DONE) begin
            for (int i = 0; i < SENSOR_COUNT; i++)
                out_scaled_reg[i] <= (cmd_reg == lscp_pkg::CMD_COMPUTE) ? scaled[i] : '0;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_position   = last_reg;
    assign m_line_found = found_reg && (cmd_reg == lscp_pkg::CMD_COMPUTE);
    assign m_scaled     = out_scaled_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("request taken while result pending");
    a_valid_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == lscp_pkg::ST_OUT) else $error("result outside output state");
    a_found_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_line_found) |-> cmd_reg == lscp_pkg::CMD_COMPUTE)
        else $error("line found without compute");
endmodule
`default_nettype wire

[sim/line_sensor_calibrate_position_top_test.sv]
module line_sensor_calibrate_position_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSENS = 5;
    localparam int SBITS = 10;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [1:0]       cmd;
        logic [SBITS-1:0] smp [NSENS];
    } request_t;

    typedef struct {
        logic signed [8:0] position;
        logic              found;
        logic [9:0]        scaled [NSENS];
    } reading_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [lscp_pkg::CFG_BITS-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_cmd = '0;
    logic [SBITS-1:0] s_sample [NSENS] = '{default: '0};
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [8:0] m_position;
    logic m_line_found;
    logic [9:0] m_scaled [NSENS];

    line_sensor_calibrate_position_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_position(m_position),
        .m_line_found(m_line_found), .m_scaled(m_scaled)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state.
    int unsigned thr_model;
    int unsigned edge_model;
    int unsigned lo_model [NSENS];
    int unsigned hi_model [NSENS];
    int          pos_model;

    request_t pending_requests [$];
    reading_t expected_readings [$];
    int errors = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int out_gap = 0;

    function automatic int unsigned scale_sample(int unsigned raw, int unsigned lo,
                                                 int unsigned hi);
        int unsigned v;
        v = raw;
        if (lo > hi) return 0;
        if (lo == hi) return 1000;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return 1000 - ((v - lo) * 1000) / (hi - lo);
    endfunction

    function automatic reading_t predict_reading(request_t rq);
        reading_t r;
        int unsigned num, den, v;
        bit hit;
        int p;
        num = 0;
        den = 0;
        hit = 0;
        r.found = 1'b0;
        for (int i = 0; i < NSENS; i++) r.scaled[i] = '0;
        case (lscp_pkg::cmd_t'(rq.cmd))
            lscp_pkg::CMD_CLEAR: begin
                for (int i = 0; i < NSENS; i++) begin
                    lo_model[i] = 1024;
                    hi_model[i] = 0;
                end
            end
            lscp_pkg::CMD_CALIBRATE: begin
                for (int i = 0; i < NSENS; i++) begin
                    if (rq.smp[i] > hi_model[i]) hi_model[i] = rq.smp[i];
                    if (rq.smp[i] < lo_model[i]) lo_model[i] = rq.smp[i];
                end
            end
            lscp_pkg::CMD_COMPUTE: begin
                for (int i = 0; i < NSENS; i++) begin
                    v = scale_sample(rq.smp[i], lo_model[i], hi_model[i]);
                    r.scaled[i] = v[9:0];
                    if (v >= thr_model) hit = 1;
                    num += v * i * 100;
                    den += v;
                end
                if (hit && den != 0) begin
                    p = int'(num / den) - 200;
                    if (p > 255) p = 255;
                    if (p < -256) p = -256;
                    pos_model = p;
                    r.found = 1'b1;
                end else begin
                    pos_model = pos_model > 0 ? int'(edge_model) : -int'(edge_model);
                end
            end
            default: ;
        endcase
        r.position = pos_model[8:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Request driver.
    int in_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_readings.push_back(predict_reading(pending_requests.pop_front()));
                in_gap = pick_gap();
                s_valid <= 1'b0;
            end else if (!s_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_requests.size() > 0) begin
                    s_cmd <= pending_requests[0].cmd;
                    s_sample <= pending_requests[0].smp;
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        reading_t e;
        bit bad;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected result pos=%0d", m_position);
                end else begin
                    e = expected_readings.pop_front();
                    bad = (m_position !== e.position) || (m_line_found !== e.found);
                    for (int i = 0; i < NSENS; i++)
                        if (m_scaled[i] !== e.scaled[i]) bad = 1;
                    if (bad) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: exp pos=%0d found=%0b sc=%p got pos=%0d found=%0b sc=%p",
                                     e.position, e.found, e.scaled,
                                     m_position, m_line_found, m_scaled);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
            end
        end
    end

    // Watchdog on accepted handshakes.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic queue_request(logic [1:0] c, int a, int b, int d, int e, int f);
        request_t rq;
        rq.cmd = c;
        rq.smp = '{a[SBITS-1:0], b[SBITS-1:0], d[SBITS-1:0], e[SBITS-1:0], f[SBITS-1:0]};
        pending_requests.push_back(rq);
    endtask

    function automatic int rs();
        return $urandom_range(0, 1023);
    endfunction

    task automatic queue_random_pass(int n);
        int base, span;
        // Sometimes clear first, then mix mostly compute readings with occasional calibrate, no-op and clear requests.
        if ($urandom_range(0, 9) == 0)
            queue_request(lscp_pkg::CMD_CLEAR, rs(), rs(), rs(), rs(), rs());
        for (int k = 0; k < n; k++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                base = $urandom_range(0, 900);
                span = $urandom_range(0, 1023 - base);
                queue_request(lscp_pkg::CMD_CALIBRATE, base + $urandom_range(0, span),
                              base + $urandom_range(0, span), base + $urandom_range(0, span),
                              base + $urandom_range(0, span), base + $urandom_range(0, span));
            end else if (r < 10) begin
                queue_request(lscp_pkg::CMD_NOP, rs(), rs(), rs(), rs(), rs());
            end else if (r < 11) begin
                queue_request(lscp_pkg::CMD_CLEAR, rs(), rs(), rs(), rs(), rs());
            end else begin
                queue_request(lscp_pkg::CMD_COMPUTE, rs(), rs(), rs(), rs(), rs());
            end
        end
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[lscp_pkg::CFG_BITS-1:0];
        if (idx == lscp_pkg::CFG_LINE_THRESHOLD) thr_model = val & 10'h3FF;
        else edge_model = val & 8'hFF;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || s_valid || expected_readings.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    initial begin
        int thr_set [6] = '{0, 1000, 1023, 1, 500, 300};
        int edge_set [6] = '{200, 0, 255, 190, 1, 100};
        thr_model = 300;
        edge_model = 190;
        pos_model = 0;
        for (int i = 0; i < NSENS; i++) begin
            lo_model[i] = 1024;
            hi_model[i] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: uncalibrated compute, zero span, full range, extremes.
        queue_request(lscp_pkg::CMD_COMPUTE, 0, 1023, 512, 0, 1023);
        queue_request(lscp_pkg::CMD_NOP, 1023, 1023, 1023, 1023, 1023);
        queue_request(lscp_pkg::CMD_CALIBRATE, 500, 500, 500, 500, 500);
        queue_request(lscp_pkg::CMD_COMPUTE, 0, 1023, 500, 499, 501);
        queue_request(lscp_pkg::CMD_CALIBRATE, 0, 0, 0, 0, 0);
        queue_request(lscp_pkg::CMD_CALIBRATE, 1023, 1023, 1023, 1023, 1023);
        queue_request(lscp_pkg::CMD_COMPUTE, 1023, 1023, 1023, 1023, 1023);
        queue_request(lscp_pkg::CMD_COMPUTE, 0, 1023, 1023, 1023, 1023);
        queue_request(lscp_pkg::CMD_COMPUTE, 1023, 1023, 1023, 1023, 0);
        queue_request(lscp_pkg::CMD_COMPUTE, 1023, 1023, 1023, 1023, 0);
        queue_request(lscp_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0);
        queue_request(lscp_pkg::CMD_COMPUTE, 341, 682, 1023, 85, 170);
        queue_request(lscp_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
        queue_request(lscp_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(lscp_pkg::CFG_LINE_THRESHOLD, thr_set[ph]);
            write_reg(lscp_pkg::CFG_EDGE_POSITION, edge_set[ph]);
            queue_request(lscp_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
            for (int k = 0; k < 4; k++)
                queue_request(lscp_pkg::CMD_CALIBRATE, rs(), rs(), rs(), rs(), rs());
            queue_random_pass(330);
            drain();
        end

        if (errors == 0 && expected_readings.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
